### sv/pab_pkg.sv
// ----------------------------------------------------------------------------
// pab_pkg
// Shared types and constants for the 16-bit pixel alpha blend unit.
// ----------------------------------------------------------------------------
package pab_pkg;

  // channel and packed pixel widths
  localparam int unsigned ChanW = 8;
  localparam int unsigned PixW  = 16;
  localparam int unsigned CfgW  = 8;
  localparam int unsigned IdxW  = 3;

  // write modes
  typedef enum logic [2:0] {
    MODE_COPY    = 3'd0,
    MODE_SPRITE  = 3'd1,
    MODE_BLEND   = 3'd2,
    MODE_MASKED  = 3'd3,
    MODE_DIRECT  = 3'd4
  } write_mode_e;

  // configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_FORMAT     = 3'd0,
    REG_MODE       = 3'd1,
    REG_MASK_RED   = 3'd2,
    REG_MASK_GREEN = 3'd3,
    REG_MASK_BLUE  = 3'd4,
    REG_MASK_ALPHA = 3'd5
  } cfg_idx_e;

  // pixel formats
  localparam logic FMT_565 = 1'b0;
  localparam logic FMT_555 = 1'b1;

  // control that travels with each word down the pipe
  typedef struct packed {
    logic            valid;
    logic            fmt;
    logic            blend;
    logic [PixW-1:0] bypass;
  } pipe_ctl_t;

  // three 8-bit channels
  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  // unpack a packed pixel to 8-bit channels, low bits zero
  function automatic rgb_t unpack(input logic fmt, input logic [PixW-1:0] p);
    rgb_t c;
    c.b = {p[4:0], 3'b000};
    if (fmt == FMT_565) begin
      c.r = {p[15:11], 3'b000};
      c.g = {p[10:5], 2'b00};
    end else begin
      c.r = {p[14:10], 3'b000};
      c.g = {p[9:5], 3'b000};
    end
    return c;
  endfunction

  // pack 8-bit channels by keeping their top bits
  function automatic logic [PixW-1:0] pack(input logic fmt, input rgb_t c);
    logic [PixW-1:0] p;
    if (fmt == FMT_565) begin
      p = {c.r[7:3], c.g[7:2], c.b[7:3]};
    end else begin
      p = {1'b0, c.r[7:3], c.g[7:3], c.b[7:3]};
    end
    return p;
  endfunction

endpackage

### sv/pab_chan.sv
// ----------------------------------------------------------------------------
// pab_chan
// One color channel of the blend: registered products s*a and d*(256-a),
// then their sum scaled down by 256.
// ----------------------------------------------------------------------------
module pab_chan (
  input  logic                      clk_i,
  input  logic [pab_pkg::ChanW-1:0] src_i,
  input  logic [pab_pkg::ChanW-1:0] dst_i,
  input  logic [pab_pkg::ChanW-1:0] alpha_i,
  output logic [pab_pkg::ChanW-1:0] mix_o
);

  logic [2*pab_pkg::ChanW-1:0] prod_s_d, prod_s_q;
  logic [2*pab_pkg::ChanW:0]   prod_d_d, prod_d_q;
  logic [pab_pkg::ChanW:0]     inv_alpha;
  logic [2*pab_pkg::ChanW:0]   sum;

  // weight of the destination
  assign inv_alpha = (pab_pkg::ChanW+1)'(1 << pab_pkg::ChanW) - {1'b0, alpha_i};

  // products
  assign prod_s_d = src_i * alpha_i;
  assign prod_d_d = dst_i * inv_alpha;

  always_ff @(posedge clk_i) begin
    prod_s_q <= prod_s_d;
    prod_d_q <= prod_d_d;
  end

  // sum stays below 2^16, so the top byte of the low 16 bits is the quotient
  assign sum   = {1'b0, prod_s_q} + prod_d_q;
  assign mix_o = sum[2*pab_pkg::ChanW-1:pab_pkg::ChanW];

endmodule

### sv/pixel_alpha_blend_16bit.sv
// ----------------------------------------------------------------------------
// pixel_alpha_blend_16bit
// Frame buffer pixel write unit: copy, sprite, blend, masked blend and
// direct 8-bit source blend for 5:6:5 and 5:5:5 pixels.
// ----------------------------------------------------------------------------
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+-----------------
//  input     | dest_pixel_i source_pixel_i source_red_i      | start, busy
//            | source_green_i source_blue_i source_alpha_i   |
//  result    | new_pixel_o                                   | done_o strobe
//  config    | cfg_idx_i cfg_data_i                          | cfg_we_i
//
//  one word enters per cycle; its result strobes out once it has passed the
//  stage 1, stage 2 and stage 3 registers; stage 1 unpacks and applies the masks,
//  stage 2 holds the channel products, stage 3 holds the packed result
//  busy stays low: the pipe never stalls since results cannot be held off
//  reset empties the pipe and loads the register defaults
// ----------------------------------------------------------------------------
module pixel_alpha_blend_16bit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic [pab_pkg::PixW-1:0]  dest_pixel_i,
  input  logic [pab_pkg::PixW-1:0]  source_pixel_i,
  input  logic [pab_pkg::ChanW-1:0] source_red_i,
  input  logic [pab_pkg::ChanW-1:0] source_green_i,
  input  logic [pab_pkg::ChanW-1:0] source_blue_i,
  input  logic [pab_pkg::ChanW-1:0] source_alpha_i,
  // result side
  output logic                      done_o,
  output logic [pab_pkg::PixW-1:0]  new_pixel_o,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [pab_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [pab_pkg::CfgW-1:0]  cfg_data_i
);

  // configuration registers
  logic                         fmt_q;
  pab_pkg::write_mode_e         mode_q;
  logic [pab_pkg::ChanW-1:0]    mask_r_q, mask_g_q, mask_b_q, mask_a_q;

  // pipeline registers
  pab_pkg::pipe_ctl_t           ctl1_d, ctl1_q, ctl2_q;
  logic                         done_q;
  logic [pab_pkg::PixW-1:0]     pix_d, pix_q;
  pab_pkg::rgb_t                src1_d, src1_q, dst1_d, dst1_q;
  logic [pab_pkg::ChanW-1:0]    alpha1_d, alpha1_q;

  // stage 1 helpers
  pab_pkg::rgb_t                src_unp, src_sel;
  logic [2*pab_pkg::ChanW-1:0]  mr_prod, mg_prod, mb_prod, ma_prod;
  logic                         accept;
  pab_pkg::rgb_t                mix;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= pab_pkg::FMT_565;
      mode_q   <= pab_pkg::MODE_BLEND;
      mask_r_q <= '1;
      mask_g_q <= '1;
      mask_b_q <= '1;
      mask_a_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pab_pkg::REG_FORMAT:     fmt_q    <= cfg_data_i[0];
        pab_pkg::REG_MODE:       mode_q   <= pab_pkg::write_mode_e'(cfg_data_i[2:0]);
        pab_pkg::REG_MASK_RED:   mask_r_q <= cfg_data_i;
        pab_pkg::REG_MASK_GREEN: mask_g_q <= cfg_data_i;
        pab_pkg::REG_MASK_BLUE:  mask_b_q <= cfg_data_i;
        pab_pkg::REG_MASK_ALPHA: mask_a_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: unpack, pick source, apply masks, resolve non-blend modes
  always_comb begin
    src_unp  = pab_pkg::unpack(fmt_q, source_pixel_i);
    dst1_d   = pab_pkg::unpack(fmt_q, dest_pixel_i);
    src_sel  = src_unp;
    if (mode_q == pab_pkg::MODE_DIRECT) begin
      src_sel.r = source_red_i;
      src_sel.g = source_green_i;
      src_sel.b = source_blue_i;
    end
    mr_prod  = src_unp.r * mask_r_q;
    mg_prod  = src_unp.g * mask_g_q;
    mb_prod  = src_unp.b * mask_b_q;
    ma_prod  = source_alpha_i * mask_a_q;
    src1_d   = src_sel;
    alpha1_d = source_alpha_i;
    if (mode_q == pab_pkg::MODE_MASKED) begin
      src1_d.r = mr_prod[2*pab_pkg::ChanW-1:pab_pkg::ChanW];
      src1_d.g = mg_prod[2*pab_pkg::ChanW-1:pab_pkg::ChanW];
      src1_d.b = mb_prod[2*pab_pkg::ChanW-1:pab_pkg::ChanW];
      alpha1_d = ma_prod[2*pab_pkg::ChanW-1:pab_pkg::ChanW];
    end
    ctl1_d.valid = accept;
    ctl1_d.fmt   = fmt_q;
    case (mode_q)
      pab_pkg::MODE_COPY: begin
        ctl1_d.blend  = 1'b0;
        ctl1_d.bypass = source_pixel_i;
      end
      pab_pkg::MODE_SPRITE: begin
        ctl1_d.blend  = 1'b0;
        ctl1_d.bypass = (source_alpha_i != '0) ? source_pixel_i : dest_pixel_i;
      end
      pab_pkg::MODE_BLEND, pab_pkg::MODE_MASKED, pab_pkg::MODE_DIRECT: begin
        ctl1_d.blend  = 1'b1;
        ctl1_d.bypass = dest_pixel_i;
      end
      default: begin
        ctl1_d.blend  = 1'b0;
        ctl1_d.bypass = dest_pixel_i;
      end
    endcase
  end

  // control and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    src1_q   <= src1_d;
    dst1_q   <= dst1_d;
    alpha1_q <= alpha1_d;
  end

  // stage 2: per-channel products
  pab_chan u_chan_r (
    .clk_i   (clk_i),
    .src_i   (src1_q.r),
    .dst_i   (dst1_q.r),
    .alpha_i (alpha1_q),
    .mix_o   (mix.r)
  );

  pab_chan u_chan_g (
    .clk_i   (clk_i),
    .src_i   (src1_q.g),
    .dst_i   (dst1_q.g),
    .alpha_i (alpha1_q),
    .mix_o   (mix.g)
  );

  pab_chan u_chan_b (
    .clk_i   (clk_i),
    .src_i   (src1_q.b),
    .dst_i   (dst1_q.b),
    .alpha_i (alpha1_q),
    .mix_o   (mix.b)
  );

  // stage 3: pack and pick the word
  assign pix_d = ctl2_q.blend ? pab_pkg::pack(ctl2_q.fmt, mix) : ctl2_q.bypass;

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign done_o      = done_q;
  assign new_pixel_o = pix_q;

`ifndef NO_ASSERTIONS
  // every word accepted strobes out on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##3 done_o)
    else $error("accepted word did not come out after three cycles");

  // no strobe without a matching accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 3))
    else $error("result strobe without an accepted word");

  // copy mode passes the source word through untouched
  a_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(mode_q == pab_pkg::MODE_COPY, 3)
      |-> new_pixel_o == $past(source_pixel_i, 3))
    else $error("copy mode changed the source word");
`endif

endmodule

### sim/pixel_alpha_blend_16bit_test.sv
// ----------------------------------------------------------------------------
// pixel_alpha_blend_16bit_test
// Self-checking testbench for the 16-bit pixel alpha blend unit. A directed
// pass covers reset defaults, every write mode, both pixel formats and the
// extreme alpha and mask values. Random register settings follow, each with
// a burst of random pixels and random idle gaps on the command side. Every
// strobed result is checked against an in-order prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pixel_alpha_blend_16bit_test;

  localparam int unsigned RandomWords = 1800;
  localparam int unsigned QuietLimit  = 400;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned SettleCycles = 4;

  // write mode codes with no defined operation
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [pab_pkg::ChanW-1:0] r;
    logic [pab_pkg::ChanW-1:0] g;
    logic [pab_pkg::ChanW-1:0] b;
  } chan3_t;

  // one accepted word with its predicted pixel
  typedef struct {
    logic [pab_pkg::PixW-1:0]  dst;
    logic [pab_pkg::PixW-1:0]  src;
    logic [pab_pkg::ChanW-1:0] r;
    logic [pab_pkg::ChanW-1:0] g;
    logic [pab_pkg::ChanW-1:0] b;
    logic [pab_pkg::ChanW-1:0] a;
    logic                      fmt;
    logic [2:0]                mode;
    logic [pab_pkg::PixW-1:0]  pixel;
  } blend_word_t;

  // predicts blended pixels and checks them in order
  class blend_scoreboard;
    logic                      fmt    = pab_pkg::FMT_565;
    logic [2:0]                mode   = pab_pkg::MODE_BLEND;
    logic [pab_pkg::ChanW-1:0] mask_r = 8'hFF;
    logic [pab_pkg::ChanW-1:0] mask_g = 8'hFF;
    logic [pab_pkg::ChanW-1:0] mask_b = 8'hFF;
    logic [pab_pkg::ChanW-1:0] mask_a = 8'hFF;
    blend_word_t               expected_words[$];
    int unsigned               words_per_mode[8];
    int unsigned               compared;
    int unsigned               failures;

    function void set_reg(pab_pkg::cfg_idx_e idx, logic [pab_pkg::CfgW-1:0] val);
      case (idx)
        pab_pkg::REG_FORMAT:     fmt    = val[0];
        pab_pkg::REG_MODE:       mode   = val[2:0];
        pab_pkg::REG_MASK_RED:   mask_r = val;
        pab_pkg::REG_MASK_GREEN: mask_g = val;
        pab_pkg::REG_MASK_BLUE:  mask_b = val;
        pab_pkg::REG_MASK_ALPHA: mask_a = val;
        default:                 ;
      endcase
    endfunction

    // packed pixel to 8-bit channels, low bits zero
    function chan3_t expand_pixel(logic [pab_pkg::PixW-1:0] p);
      chan3_t c;
      c.b = {p[4:0], 3'b000};
      if (fmt == pab_pkg::FMT_565) begin
        c.r = {p[15:11], 3'b000};
        c.g = {p[10:5], 2'b00};
      end else begin
        c.r = {p[14:10], 3'b000};
        c.g = {p[9:5], 3'b000};
      end
      return c;
    endfunction

    function logic [pab_pkg::PixW-1:0] pack_channels(chan3_t c);
      if (fmt == pab_pkg::FMT_565) return {c.r[7:3], c.g[7:2], c.b[7:3]};
      return {1'b0, c.r[7:3], c.g[7:3], c.b[7:3]};
    endfunction

    function logic [pab_pkg::ChanW-1:0] scale(logic [pab_pkg::ChanW-1:0] v,
                                              logic [pab_pkg::ChanW-1:0] m);
      return 8'((int'(v) * int'(m)) >> 8);
    endfunction

    // (s*a + d*(256-a)) / 256, truncated
    function logic [pab_pkg::ChanW-1:0] mix_channel(logic [pab_pkg::ChanW-1:0] s,
                                                    logic [pab_pkg::ChanW-1:0] d,
                                                    logic [pab_pkg::ChanW-1:0] a);
      int unsigned sum;
      sum = s * a + d * (256 - a);
      return 8'(sum >> 8);
    endfunction

    function logic [pab_pkg::PixW-1:0] blend_pixel(blend_word_t w);
      chan3_t                    s;
      chan3_t                    d;
      chan3_t                    o;
      logic [pab_pkg::ChanW-1:0] al;
      logic [pab_pkg::PixW-1:0]  res;
      case (w.mode)
        pab_pkg::MODE_COPY:   res = w.src;
        pab_pkg::MODE_SPRITE: res = (w.a != 8'd0) ? w.src : w.dst;
        pab_pkg::MODE_BLEND, pab_pkg::MODE_MASKED, pab_pkg::MODE_DIRECT: begin
          d  = expand_pixel(w.dst);
          al = w.a;
          if (w.mode == pab_pkg::MODE_DIRECT) begin
            s = '{r: w.r, g: w.g, b: w.b};
          end else begin
            s = expand_pixel(w.src);
          end
          // masked blend scales alpha and source first
          if (w.mode == pab_pkg::MODE_MASKED) begin
            al  = scale(al, mask_a);
            s.r = scale(s.r, mask_r);
            s.g = scale(s.g, mask_g);
            s.b = scale(s.b, mask_b);
          end
          o.r = mix_channel(s.r, d.r, al);
          o.g = mix_channel(s.g, d.g, al);
          o.b = mix_channel(s.b, d.b, al);
          res = pack_channels(o);
        end
        default: res = w.dst;
      endcase
      return res;
    endfunction

    function void note_input(logic [pab_pkg::PixW-1:0] dst, logic [pab_pkg::PixW-1:0] src,
                             logic [pab_pkg::ChanW-1:0] r, logic [pab_pkg::ChanW-1:0] g,
                             logic [pab_pkg::ChanW-1:0] b, logic [pab_pkg::ChanW-1:0] a);
      blend_word_t w;
      w = '{dst: dst, src: src, r: r, g: g, b: b, a: a, fmt: fmt, mode: mode,
            pixel: '0};
      w.pixel = blend_pixel(w);
      words_per_mode[mode]++;
      expected_words.push_back(w);
    endfunction

    function void check_result(logic [pab_pkg::PixW-1:0] got);
      blend_word_t w;
      compared++;
      if (expected_words.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("%0t: unexpected result %h with no word pending", $realtime, got);
      end else begin
        w = expected_words.pop_front();
        if (got !== w.pixel) begin
          failures++;
          if (failures <= MaxReports) begin
            $display("%0t: mismatch mode %0d fmt %0d dst %h src %h rgb %h/%h/%h alpha %h",
                     $realtime, w.mode, w.fmt, w.dst, w.src, w.r, w.g, w.b, w.a);
            $display("    expected %h got %h", w.pixel, got);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void close_out();
      if (expected_words.size() != 0) begin
        failures += expected_words.size();
        $display("%0d expected pixels never arrived", expected_words.size());
      end
    endfunction
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      start       = 1'b0;
  logic                      busy;
  logic [pab_pkg::PixW-1:0]  dest_pixel  = '0;
  logic [pab_pkg::PixW-1:0]  src_pixel   = '0;
  logic [pab_pkg::ChanW-1:0] src_red     = '0;
  logic [pab_pkg::ChanW-1:0] src_green   = '0;
  logic [pab_pkg::ChanW-1:0] src_blue    = '0;
  logic [pab_pkg::ChanW-1:0] src_alpha   = '0;
  logic                      done_o;
  logic [pab_pkg::PixW-1:0]  new_pixel;
  logic                      cfg_we      = 1'b0;
  pab_pkg::cfg_idx_e         cfg_idx     = pab_pkg::REG_FORMAT;
  logic [pab_pkg::CfgW-1:0]  cfg_data    = '0;

  blend_scoreboard sb = new;
  int unsigned     quiet_cycles;
  int unsigned     words_sent;
  int unsigned     settings_used;
  bit              calm;

  pixel_alpha_blend_16bit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .dest_pixel_i   (dest_pixel),
    .source_pixel_i (src_pixel),
    .source_red_i   (src_red),
    .source_green_i (src_green),
    .source_blue_i  (src_blue),
    .source_alpha_i (src_alpha),
    .done_o         (done_o),
    .new_pixel_o    (new_pixel),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // accepted words, strobed results and the quiet-cycle watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy)
        sb.note_input(dest_pixel, src_pixel, src_red, src_green, src_blue, src_alpha);
      if (done_o) sb.check_result(new_pixel);
      if ((start && !busy) || done_o || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no activity for %0d cycles", $realtime, QuietLimit);
        $display("pixel_alpha_blend_16bit_test: FAIL");
        $finish;
      end
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [pab_pkg::ChanW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [pab_pkg::PixW-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // present one word and hold it until accepted
  task automatic send_pixel(input logic [pab_pkg::PixW-1:0] dst,
                            input logic [pab_pkg::PixW-1:0] src,
                            input logic [pab_pkg::ChanW-1:0] r,
                            input logic [pab_pkg::ChanW-1:0] g,
                            input logic [pab_pkg::ChanW-1:0] b,
                            input logic [pab_pkg::ChanW-1:0] a);
    int unsigned gap;
    gap        = pick_gap();
    start      <= 1'b1;
    dest_pixel <= dst;
    src_pixel  <= src;
    src_red    <= r;
    src_green  <= g;
    src_blue   <= b;
    src_alpha  <= a;
    do @(posedge clk_i); while (busy);
    words_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending and let the pipe empty
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input pab_pkg::cfg_idx_e idx,
                           input logic [pab_pkg::CfgW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic fmt, input logic [2:0] mode,
                            input logic [pab_pkg::ChanW-1:0] mr,
                            input logic [pab_pkg::ChanW-1:0] mg,
                            input logic [pab_pkg::ChanW-1:0] mb,
                            input logic [pab_pkg::ChanW-1:0] ma);
    wait_idle();
    write_reg(pab_pkg::REG_FORMAT, {7'd0, fmt});
    write_reg(pab_pkg::REG_MODE, {5'd0, mode});
    write_reg(pab_pkg::REG_MASK_RED, mr);
    write_reg(pab_pkg::REG_MASK_GREEN, mg);
    write_reg(pab_pkg::REG_MASK_BLUE, mb);
    write_reg(pab_pkg::REG_MASK_ALPHA, ma);
    settings_used++;
  endtask

  initial begin
    logic [2:0]  mode;
    int unsigned roll;
    int unsigned burst;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: 5:6:5 blend, masks full
    settings_used = 1;
    send_pixel(16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_pixel(16'hFFFF, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h80);
    send_pixel(16'hF81F, 16'h07E0, 8'h00, 8'h00, 8'h00, 8'h01);

    // copy ignores alpha
    set_config(pab_pkg::FMT_565, pab_pkg::MODE_COPY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'h1234, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // sprite: zero alpha keeps destination
    set_config(pab_pkg::FMT_555, pab_pkg::MODE_SPRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'hAAAA, 16'h5555, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(16'hAAAA, 16'h5555, 8'h00, 8'h00, 8'h00, 8'h01);
    send_pixel(16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFF);

    // 5:5:5 blend drops bit 15
    set_config(pab_pkg::FMT_555, pab_pkg::MODE_BLEND, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h80);
    send_pixel(16'h8000, 16'h7FFF, 8'h00, 8'h00, 8'h00, 8'hFF);

    // masked blend with zero and full masks
    set_config(pab_pkg::FMT_565, pab_pkg::MODE_MASKED, 8'h00, 8'hFF, 8'h80, 8'hFF);
    send_pixel(16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_pixel(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'h80);
    set_config(pab_pkg::FMT_555, pab_pkg::MODE_MASKED, 8'hFF, 8'h00, 8'hFF, 8'h00);
    send_pixel(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00, 8'hFF);

    // direct blend takes 8-bit source channels
    set_config(pab_pkg::FMT_565, pab_pkg::MODE_DIRECT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'h0000, 16'h1234, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    send_pixel(16'hFFFF, 16'h0000, 8'h00, 8'hFF, 8'h00, 8'h80);
    set_config(pab_pkg::FMT_555, pab_pkg::MODE_DIRECT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);

    // undefined modes pass the destination through
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
      set_config(pab_pkg::FMT_565, 3'(m), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(16'hBEEF, 16'h1234, 8'h55, 8'hAA, 8'h0F, 8'hFF);
    end

    // random settings, each followed by a burst of random words
    burst = 0;
    while (burst < RandomWords) begin
      roll = $urandom_range(0, 19);
      mode = (roll < 18) ? 3'(roll % 5) : 3'(MODE_UNUSED_FIRST + $urandom_range(0, 2));
      set_config(1'($urandom_range(0, 1)), mode, pick_byte(), pick_byte(), pick_byte(),
                 pick_byte());
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(80, 200)) begin
        send_pixel(pick_pixel(), pick_pixel(), pick_byte(), pick_byte(), pick_byte(),
                   pick_byte());
        burst++;
        // now and then drain the pipe mid-burst
        if ($urandom_range(0, 199) == 0) wait_idle();
      end
    end

    wait_idle();
    sb.close_out();
    $display("sent %0d words under %0d register settings: copy %0d sprite %0d blend %0d",
             words_sent, settings_used, sb.words_per_mode[pab_pkg::MODE_COPY],
             sb.words_per_mode[pab_pkg::MODE_SPRITE], sb.words_per_mode[pab_pkg::MODE_BLEND]);
    $display("masked %0d direct %0d undefined modes %0d, %0d results compared",
             sb.words_per_mode[pab_pkg::MODE_MASKED], sb.words_per_mode[pab_pkg::MODE_DIRECT],
             sb.words_per_mode[5] + sb.words_per_mode[6] + sb.words_per_mode[7],
             sb.compared);
    if (sb.failures == 0) begin
      $display("pixel_alpha_blend_16bit_test: PASS");
    end else begin
      $display("%0d failures", sb.failures);
      $display("pixel_alpha_blend_16bit_test: FAIL");
    end
    $finish;
  end

endmodule
